// File: sv/ctd_pkg.sv
// ----------------------------------------------------------------------------
// ctd_pkg: chunked transfer decoder definitions
// Transaction payload types, phase and number-parser codes, character helpers.
// ----------------------------------------------------------------------------
package ctd_pkg;

  localparam int unsigned SizeBitsDef   = 32;
  localparam int unsigned LineBufferDef = 32;

  localparam logic [7:0] CharCr    = 8'h0d;
  localparam logic [7:0] CharLf    = 8'h0a;
  localparam logic [7:0] CharPlus  = 8'h2b;
  localparam logic [7:0] CharMinus = 8'h2d;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharXLow  = 8'h78;
  localparam logic [7:0] CharXUp   = 8'h58;

  // decoder phase
  localparam logic [2:0] PH_SIZE = 3'd0;
  localparam logic [2:0] PH_DATA = 3'd1;
  localparam logic [2:0] PH_DCR  = 3'd2;
  localparam logic [2:0] PH_DLF  = 3'd3;
  localparam logic [2:0] PH_DONE = 3'd4;
  localparam logic [2:0] PH_ERR  = 3'd5;

  // size number parser stage
  localparam logic [2:0] NS_WS        = 3'd0;
  localparam logic [2:0] NS_SIGN      = 3'd1;
  localparam logic [2:0] NS_ZERO      = 3'd2;
  localparam logic [2:0] NS_XPEND     = 3'd3;
  localparam logic [2:0] NS_DIGITS    = 3'd4;
  localparam logic [2:0] NS_STOP_OK   = 3'd5;
  localparam logic [2:0] NS_STOP_NONE = 3'd6;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_status;
    logic       status;
  } out_t;

  // bit 4 set when c is a hex digit, low nibble holds its value
  function automatic logic [4:0] hex_val(logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  function automatic logic is_ws(logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
  endfunction

endpackage

// File: sv/chunked_transfer_decoder.sv
// ----------------------------------------------------------------------------
// chunked_transfer_decoder: HTTP chunked body decoder
// Output: each result is registered in out_q, or in the skid entry while out_q is held.
// Throughput: one byte per cycle while in_ready_o is high; the whole size-line/data
//   state update is a single registered pass, and a two-entry output stage absorbs stalls.
// Reset: asynchronous; decoder returns to size-line parsing, output empty.
// After each end-of-body status the decoder starts over for a new body.
// ----------------------------------------------------------------------------
module chunked_transfer_decoder #(
  parameter int unsigned SIZE_BITS   = ctd_pkg::SizeBitsDef,
  parameter int unsigned LINE_BUFFER = ctd_pkg::LineBufferDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ctd_pkg::in_t  in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ctd_pkg::out_t out_o
);

  localparam int unsigned LCW = $clog2(LINE_BUFFER + 1);

  typedef struct packed {
    logic [2:0]           phase;
    logic [SIZE_BITS-1:0] val;
    logic                 ovf;
    logic [LCW-1:0]       cnt;
    logic [2:0]           stage;
    logic                 neg;
  } line_t;

  function automatic line_t accumulate(line_t s, logic [3:0] d);
    line_t r;
    r = s;
    if (s.val[SIZE_BITS-1:SIZE_BITS-4] != 4'd0) r.ovf = 1'b1;
    r.val   = {s.val[SIZE_BITS-5:0], d};
    r.stage = ctd_pkg::NS_DIGITS;
    return r;
  endfunction

  function automatic line_t line_char(line_t s, logic [7:0] c);
    line_t      r;
    logic [4:0] h;
    r = s;
    h = ctd_pkg::hex_val(c);
    r.cnt = s.cnt + 1'b1;
    if (r.cnt >= LCW'(LINE_BUFFER)) begin
      r.phase = ctd_pkg::PH_ERR;
    end else begin
      case (s.stage)
        ctd_pkg::NS_WS, ctd_pkg::NS_SIGN: begin
          if (s.stage == ctd_pkg::NS_WS && ctd_pkg::is_ws(c)) begin
            r.stage = ctd_pkg::NS_WS;
          end else if (s.stage == ctd_pkg::NS_WS &&
                       (c == ctd_pkg::CharPlus || c == ctd_pkg::CharMinus)) begin
            r.neg   = (c == ctd_pkg::CharMinus);
            r.stage = ctd_pkg::NS_SIGN;
          end else if (c == ctd_pkg::CharZero) begin
            r.stage = ctd_pkg::NS_ZERO;
          end else if (h[4]) begin
            r = accumulate(r, h[3:0]);
          end else begin
            r.stage = ctd_pkg::NS_STOP_NONE;
          end
        end
        ctd_pkg::NS_ZERO: begin
          if (c == ctd_pkg::CharXLow || c == ctd_pkg::CharXUp) begin
            r.stage = ctd_pkg::NS_XPEND;
          end else if (h[4]) begin
            r = accumulate(r, h[3:0]);
          end else begin
            r.stage = ctd_pkg::NS_STOP_OK;
          end
        end
        ctd_pkg::NS_XPEND, ctd_pkg::NS_DIGITS: begin
          if (h[4]) begin
            r = accumulate(r, h[3:0]);
          end else begin
            r.stage = ctd_pkg::NS_STOP_OK;
          end
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  // decoder state
  line_t                ln_q, ln_d;
  logic                 pcr_q, pcr_d;
  logic [SIZE_BITS-1:0] left_q, left_d;

  // output register plus skid entry
  logic          out_valid_q, sk_valid_q;
  ctd_pkg::out_t out_q, sk_q;

  logic          in_fire, out_fire, emit, push;
  ctd_pkg::out_t res;
  line_t         ln_t;
  logic          digits;

  assign in_ready_o  = !sk_valid_q;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_fire    = out_valid_q && out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_comb begin
    ln_d   = ln_q;
    pcr_d  = pcr_q;
    left_d = left_q;
    emit   = 1'b0;
    ln_t   = ln_q;
    digits = 1'b0;
    case (ln_q.phase)
      ctd_pkg::PH_SIZE: begin
        if (pcr_q && in_i.in_byte == ctd_pkg::CharLf) begin
          // line end
          digits = (ln_q.stage == ctd_pkg::NS_ZERO) ||
                   (ln_q.stage == ctd_pkg::NS_XPEND) ||
                   (ln_q.stage == ctd_pkg::NS_DIGITS) ||
                   (ln_q.stage == ctd_pkg::NS_STOP_OK);
          ln_d       = '0;
          ln_d.stage = ctd_pkg::NS_WS;
          pcr_d      = 1'b0;
          if (!digits || ln_q.ovf) begin
            ln_d.phase = ctd_pkg::PH_ERR;
          end else if (ln_q.val == '0) begin
            ln_d.phase = ctd_pkg::PH_DONE;
          end else if (ln_q.neg) begin
            ln_d.phase = ctd_pkg::PH_ERR;
          end else begin
            left_d     = ln_q.val;
            ln_d.phase = ctd_pkg::PH_DATA;
          end
        end else if (pcr_q) begin
          // lone CR counts as a line character
          ln_t = line_char(ln_q, ctd_pkg::CharCr);
          ln_d = ln_t;
          if (ln_t.phase == ctd_pkg::PH_SIZE && in_i.in_byte != ctd_pkg::CharCr) begin
            pcr_d = 1'b0;
            ln_d  = line_char(ln_t, in_i.in_byte);
          end
        end else if (in_i.in_byte == ctd_pkg::CharCr) begin
          pcr_d = 1'b1;
        end else begin
          ln_d = line_char(ln_q, in_i.in_byte);
        end
      end
      ctd_pkg::PH_DATA: begin
        emit   = 1'b1;
        left_d = left_q - 1'b1;
        if (left_d == '0) ln_d.phase = ctd_pkg::PH_DCR;
      end
      ctd_pkg::PH_DCR: begin
        ln_d.phase = (in_i.in_byte == ctd_pkg::CharCr) ? ctd_pkg::PH_DLF : ctd_pkg::PH_ERR;
      end
      ctd_pkg::PH_DLF: begin
        ln_d.phase = (in_i.in_byte == ctd_pkg::CharLf) ? ctd_pkg::PH_SIZE : ctd_pkg::PH_ERR;
      end
      ctd_pkg::PH_DONE: ;
      default: ln_d.phase = ctd_pkg::PH_ERR;
    endcase

    res.out_byte  = in_i.in_byte;
    res.is_status = 1'b0;
    res.status    = ctd_pkg::STATUS_OK;
    push          = emit;
    if (in_i.in_last) begin
      push          = 1'b1;
      res.out_byte  = 8'd0;
      res.is_status = 1'b1;
      res.status    = (ln_d.phase == ctd_pkg::PH_DONE) ? ctd_pkg::STATUS_OK
                                                        : ctd_pkg::STATUS_ERR;
      ln_d          = '0;
      ln_d.phase    = ctd_pkg::PH_SIZE;
      ln_d.stage    = ctd_pkg::NS_WS;
      pcr_d         = 1'b0;
      left_d        = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ln_q       <= '0;
      ln_q.phase <= ctd_pkg::PH_SIZE;
      ln_q.stage <= ctd_pkg::NS_WS;
      pcr_q      <= 1'b0;
      left_q     <= '0;
    end else if (in_fire) begin
      ln_q   <= ln_d;
      pcr_q  <= pcr_d;
      left_q <= left_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sk_valid_q  <= 1'b0;
    end else if (!out_valid_q || out_fire) begin
      if (sk_valid_q) begin
        out_valid_q <= 1'b1;
        sk_valid_q  <= in_fire && push;
      end else begin
        out_valid_q <= in_fire && push;
      end
    end else if (in_fire && push) begin
      sk_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_fire) begin
      if (sk_valid_q) begin
        out_q <= sk_q;
        sk_q  <= res;
      end else begin
        out_q <= res;
      end
    end else if (in_fire && push) begin
      sk_q <= res;
    end
  end

  // skid entry is only used behind a full output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sk_valid_q |-> out_valid_q)
    else $error("skid entry occupied with empty output register");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ln_q.phase == ctd_pkg::PH_DATA) |-> (left_q != '0))
    else $error("data phase with no bytes left");

  // the count stops at the limit, which puts the body in error
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ln_q.cnt <= LCW'(LINE_BUFFER))
    else $error("size line count past buffer limit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.in_last) |=> (ln_q.phase == ctd_pkg::PH_SIZE && ln_q.cnt == '0 &&
                                   !pcr_q))
    else $error("decoder not restarted after end of body");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_o.is_status) |-> (out_o.status == ctd_pkg::STATUS_OK))
    else $error("payload transaction carries a status");

endmodule

// File: bench/chunked_transfer_decoder_tb.sv
// ----------------------------------------------------------------------------
// chunked_transfer_decoder_tb: self-checking bench for the chunked decoder
// Feeds whole chunked bodies one byte per transaction, predicts every payload
// byte and end-of-body status, and compares them with the block's results
// under random sender gaps, receiver stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module chunked_transfer_decoder_tb;

  localparam int unsigned SizeBits   = ctd_pkg::SizeBitsDef;
  localparam int unsigned LineLimit  = ctd_pkg::LineBufferDef;
  localparam logic [63:0] SizeMask   = {64{1'b1}} >> (64 - SizeBits);
  localparam int unsigned MaxPrinted = 40;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  ctd_pkg::in_t  in_pkt = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  ctd_pkg::out_t out_pkt;

  chunked_transfer_decoder uut (
    .clk_i(clk),
    .rst_ni(rst_n),
    .in_valid_i(in_valid),
    .in_ready_o(in_ready),
    .in_i(in_pkt),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_o(out_pkt)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // decoder shadow state
  logic [2:0]  dec_phase;
  logic [2:0]  num_stage;
  logic [63:0] chunk_size;
  logic [63:0] data_left;
  logic        size_ovf;
  logic        neg_sign;
  logic        cr_held;
  int unsigned line_len;

  ctd_pkg::out_t decoded_q[$];
  logic [7:0]    body_q[$];

  int unsigned fail_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned send_gap_pct = 0;
  int unsigned recv_gap_pct = 0;
  int unsigned hold_req = 0;
  int unsigned hold_left = 0;

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    fail_count++;
    if (fail_count <= MaxPrinted) begin
      $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
    end
  endtask

  // ---------------------------------------------------------------- predictor
  function automatic int nibble_of(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == " " || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  function automatic void restart_body();
    dec_phase  = ctd_pkg::PH_SIZE;
    num_stage  = ctd_pkg::NS_WS;
    chunk_size = '0;
    data_left  = '0;
    size_ovf   = 1'b0;
    neg_sign   = 1'b0;
    cr_held    = 1'b0;
    line_len   = 0;
  endfunction

  function automatic void shift_in_digit(logic [3:0] d);
    if ((chunk_size >> (SizeBits - 4)) != 0) size_ovf = 1'b1;
    chunk_size = ((chunk_size << 4) | 64'(d)) & SizeMask;
  endfunction

  function automatic void parse_size_char(logic [7:0] c);
    int h;
    h = nibble_of(c);
    line_len++;
    if (line_len >= LineLimit) begin
      dec_phase = ctd_pkg::PH_ERR;
      return;
    end
    case (num_stage)
      ctd_pkg::NS_WS, ctd_pkg::NS_SIGN: begin
        if (num_stage == ctd_pkg::NS_WS && is_blank(c)) return;
        if (num_stage == ctd_pkg::NS_WS &&
            (c == ctd_pkg::CharPlus || c == ctd_pkg::CharMinus)) begin
          neg_sign  = (c == ctd_pkg::CharMinus);
          num_stage = ctd_pkg::NS_SIGN;
        end else if (c == ctd_pkg::CharZero) begin
          num_stage = ctd_pkg::NS_ZERO;
        end else if (h >= 0) begin
          shift_in_digit(h[3:0]);
          num_stage = ctd_pkg::NS_DIGITS;
        end else begin
          num_stage = ctd_pkg::NS_STOP_NONE;
        end
      end
      ctd_pkg::NS_ZERO: begin
        if (c == ctd_pkg::CharXLow || c == ctd_pkg::CharXUp) begin
          num_stage = ctd_pkg::NS_XPEND;
        end else if (h >= 0) begin
          shift_in_digit(h[3:0]);
          num_stage = ctd_pkg::NS_DIGITS;
        end else begin
          num_stage = ctd_pkg::NS_STOP_OK;
        end
      end
      ctd_pkg::NS_XPEND, ctd_pkg::NS_DIGITS: begin
        if (h >= 0) begin
          shift_in_digit(h[3:0]);
          num_stage = ctd_pkg::NS_DIGITS;
        end else begin
          num_stage = ctd_pkg::NS_STOP_OK;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void close_size_line();
    bit had_digits;
    had_digits = num_stage == ctd_pkg::NS_ZERO || num_stage == ctd_pkg::NS_XPEND ||
                 num_stage == ctd_pkg::NS_DIGITS || num_stage == ctd_pkg::NS_STOP_OK;
    if (!had_digits || size_ovf) begin
      dec_phase = ctd_pkg::PH_ERR;
    end else if (chunk_size == 0) begin
      dec_phase = ctd_pkg::PH_DONE;
    end else if (neg_sign) begin
      dec_phase = ctd_pkg::PH_ERR;
    end else begin
      data_left = chunk_size;
      dec_phase = ctd_pkg::PH_DATA;
    end
    chunk_size = '0;
    size_ovf   = 1'b0;
    line_len   = 0;
    num_stage  = ctd_pkg::NS_WS;
    neg_sign   = 1'b0;
    cr_held    = 1'b0;
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic last);
    ctd_pkg::out_t res;
    bit            pass_on;
    pass_on = 1'b0;
    case (dec_phase)
      ctd_pkg::PH_SIZE: begin
        if (cr_held) begin
          if (b == ctd_pkg::CharLf) begin
            close_size_line();
          end else begin
            // CR without LF counts as a line character
            parse_size_char(ctd_pkg::CharCr);
            if (dec_phase == ctd_pkg::PH_SIZE && b != ctd_pkg::CharCr) begin
              cr_held = 1'b0;
              parse_size_char(b);
            end
          end
        end else if (b == ctd_pkg::CharCr) begin
          cr_held = 1'b1;
        end else begin
          parse_size_char(b);
        end
      end
      ctd_pkg::PH_DATA: begin
        pass_on = 1'b1;
        data_left--;
        if (data_left == 0) dec_phase = ctd_pkg::PH_DCR;
      end
      ctd_pkg::PH_DCR:
        dec_phase = (b == ctd_pkg::CharCr) ? ctd_pkg::PH_DLF : ctd_pkg::PH_ERR;
      ctd_pkg::PH_DLF:
        dec_phase = (b == ctd_pkg::CharLf) ? ctd_pkg::PH_SIZE : ctd_pkg::PH_ERR;
      ctd_pkg::PH_DONE: ;
      default: dec_phase = ctd_pkg::PH_ERR;
    endcase
    if (last) begin
      res.out_byte  = 8'h00;
      res.is_status = 1'b1;
      res.status    = (dec_phase == ctd_pkg::PH_DONE) ? ctd_pkg::STATUS_OK
                                                      : ctd_pkg::STATUS_ERR;
      decoded_q.push_back(res);
      restart_body();
    end else if (pass_on) begin
      res.out_byte  = b;
      res.is_status = 1'b0;
      res.status    = ctd_pkg::STATUS_OK;
      decoded_q.push_back(res);
    end
  endfunction

  // ---------------------------------------------------------------- driving
  task automatic send_byte(input logic [7:0] b, input logic last);
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_pkt.in_byte <= b;
    in_pkt.in_last <= last;
    do @(posedge clk); while (!in_ready);
    decode_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_body();
    if (body_q.size() == 0) body_q.push_back(8'($urandom));
    for (int i = 0; i < body_q.size(); i++) begin
      send_byte(body_q[i], i == body_q.size() - 1);
    end
    body_q.delete();
  endtask

  // receiver: random stalls plus an occasional long hold-off
  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  always @(posedge clk) begin : check_out
    ctd_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (decoded_q.size() == 0) begin
        report_mismatch("unexpected result", out_pkt.out_byte, 8'h00);
      end else begin
        want = decoded_q.pop_front();
        if (out_pkt.out_byte !== want.out_byte)
          report_mismatch("out_byte", out_pkt.out_byte, want.out_byte);
        if (out_pkt.is_status !== want.is_status)
          report_mismatch("is_status", 8'(out_pkt.is_status), 8'(want.is_status));
        if (out_pkt.status !== want.status)
          report_mismatch("status", 8'(out_pkt.status), 8'(want.status));
      end
    end
  end

  // ---------------------------------------------------------------- body builders
  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) body_q.push_back(s[i]);
  endfunction

  function automatic void add_crlf();
    body_q.push_back(ctd_pkg::CharCr);
    body_q.push_back(ctd_pkg::CharLf);
  endfunction

  function automatic void add_random_bytes(int unsigned n);
    repeat (n) body_q.push_back(8'($urandom));
  endfunction

  function automatic void add_hex(logic [63:0] v, bit lead_zero);
    bit         started;
    logic [3:0] nib;
    started = 1'b0;
    if (lead_zero) body_q.push_back(ctd_pkg::CharZero);
    for (int i = 15; i >= 0; i--) begin
      nib = v[i*4 +: 4];
      if (nib != 0 || i == 0) started = 1'b1;
      if (started) begin
        if (nib < 10) body_q.push_back(8'(ctd_pkg::CharZero + nib));
        else body_q.push_back(8'(($urandom_range(1) ? "A" : "a") + nib - 10));
      end
    end
  endfunction

  // leading white space, including a lone CR
  function automatic void add_blanks(int unsigned n);
    repeat (n) begin
      case ($urandom_range(5))
        0: body_q.push_back(" ");
        1: body_q.push_back(8'h09);
        2: body_q.push_back(8'h0b);
        3: body_q.push_back(8'h0c);
        4: body_q.push_back(ctd_pkg::CharLf);
        default: begin
          body_q.push_back(ctd_pkg::CharCr);
          body_q.push_back(" ");
        end
      endcase
    end
  endfunction

  function automatic logic [7:0] noise_byte();
    string pool;
    pool = "0123456789aAfFgxX+-; ";
    case ($urandom_range(3))
      0: return ctd_pkg::CharCr;
      1: return ctd_pkg::CharLf;
      2: return pool[$urandom_range(pool.len() - 1)];
      default: return 8'($urandom);
    endcase
  endfunction

  // one chunk; returns 1 when the body is cut off inside it
  function automatic bit add_chunk();
    int unsigned fault;
    int unsigned len;
    fault = $urandom_range(99);
    len   = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
    if ($urandom_range(3) == 0) add_blanks($urandom_range(1, 3));
    if (fault < 4) begin
      add_hex({28'd0, 4'($urandom_range(1, 15)), 32'($urandom)}, 1'b0);
    end else if (fault < 8) begin
      case ($urandom_range(2))
        0: add_text("g");
        1: add_text("+;x");
        default: ;
      endcase
    end else if (fault < 12) begin
      add_text("-");
      add_hex(64'(len), 1'b0);
    end else if (fault < 16) begin
      // pad around the line length limit
      repeat ($urandom_range(26, 32)) body_q.push_back(" ");
      add_hex(64'(len), 1'b0);
    end else if (fault < 20) begin
      if ($urandom_range(1)) add_hex(64'hffff_ffff, 1'b0);
      else add_hex(64'(len + 5), 1'b0);
      add_crlf();
      add_random_bytes($urandom_range(0, len));
      return 1'b1;
    end else begin
      if ($urandom_range(9) == 0) body_q.push_back(ctd_pkg::CharPlus);
      if ($urandom_range(6) == 0) add_text($urandom_range(1) ? "0x" : "0X");
      add_hex(64'(len), $urandom_range(7) == 0);
    end
    if ($urandom_range(6) == 0) add_text(";ext=1");
    if ($urandom_range(19) == 0) body_q.push_back(ctd_pkg::CharCr);
    add_crlf();
    add_random_bytes(len);
    if (fault >= 20 && fault < 24) begin
      body_q.push_back(8'($urandom));
      body_q.push_back(ctd_pkg::CharLf);
    end else begin
      add_crlf();
    end
    return 1'b0;
  endfunction

  function automatic void make_random_body();
    int unsigned nchunks;
    int unsigned term;
    bit          cut;
    cut = 1'b0;
    if ($urandom_range(99) < 8) begin
      repeat ($urandom_range(1, 12)) body_q.push_back(noise_byte());
      return;
    end
    nchunks = $urandom_range(0, 3);
    for (int i = 0; i < nchunks && !cut; i++) cut = add_chunk();
    if (cut) return;
    term = $urandom_range(19);
    if (term == 0) return;  // terminator missing
    add_blanks($urandom_range(0, 1));
    case (term)
      1: add_text("-0");
      2: add_text("0x0;end");
      3: add_text("000");
      default: add_text("0");
    endcase
    add_crlf();
    if ($urandom_range(2) == 0) add_crlf();
    if ($urandom_range(4) == 0) add_random_bytes($urandom_range(1, 4));
  endfunction

  // ---------------------------------------------------------------- tests
  task automatic test_basic_framing();
    add_text("2");
    add_crlf();
    body_q.push_back(8'h00);
    body_q.push_back(8'hff);
    add_crlf();
    add_text("0");
    add_crlf();
    send_body();
  endtask

  task automatic test_size_line_syntax();
    // minus zero with a bare prefix, junk after the end ignored
    add_text("-0x");
    add_crlf();
    add_text("Z");
    send_body();
    // lone CR as white space, negative size with trailing text
    body_q.push_back(" ");
    body_q.push_back(ctd_pkg::CharCr);
    add_text("-1;x");
    add_crlf();
    send_body();
  endtask

  task automatic test_last_byte_handling();
    // data byte marked last is swallowed, body ends in error
    add_text("1");
    add_crlf();
    add_text("A");
    send_body();
  endtask

  task automatic test_output_stall();
    send_gap_pct = 0;
    recv_gap_pct = 0;
    hold_req = 80;
    add_text("40");
    add_crlf();
    add_random_bytes(64);
    add_crlf();
    add_text("0");
    add_crlf();
    send_body();
  endtask

  task automatic test_random_traffic(input int unsigned snd_pct, input int unsigned rcv_pct,
                                     input int unsigned n_bytes);
    int unsigned start;
    send_gap_pct = snd_pct;
    recv_gap_pct = rcv_pct;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      make_random_body();
      send_body();
    end
  endtask

  initial begin
    restart_body();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    send_gap_pct = 36;
    recv_gap_pct = 61;
    test_basic_framing();
    test_size_line_syntax();
    test_last_byte_handling();
    test_random_traffic(36, 61, 180);
    test_random_traffic(61, 36, 180);
    test_output_stall();
    test_random_traffic(0, 0, 180);
    @(negedge clk);
    in_valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
